// ===== sv/hbs_pkg.sv =====
// Shared types, widths, register indexes and arithmetic helpers of the height grid sampler.
`default_nettype none

package hbs_pkg;

  // Default grid limits
  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 256;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL     = 3'd4;

  // Item kinds carried on tuser
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Field widths
  localparam int SIZE_REG_W = 9;
  localparam int INV_W      = 25;
  localparam int HGT_W      = 32;
  localparam int IN_DATA_W  = 112;
  localparam int WEIGHT_W   = 17;

  // Shared multiplier: 33-bit signed difference by 26-bit signed factor
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Weight of a full step, one in Q16.16
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [INV_W-1:0]    INV_ONE    = 25'd65536;

  // a + floor(prod / 65536); the product of a blend fits in 50 signed bits
  function automatic logic signed [34:0] blend_sum(input logic signed [HGT_W-1:0] a,
                                                   input logic signed [PROD_W-1:0] prod);
    logic signed [34:0] a_ext;
    logic signed [34:0] step;
    a_ext = 35'(a);
    step  = prod[50:16];
    return a_ext + step;
  endfunction

  // Clip a blend result to the signed 32-bit range
  function automatic logic signed [HGT_W-1:0] saturate(input logic signed [34:0] v);
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    hi = 35'sh0_7FFF_FFFF;
    lo = -35'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[HGT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/hbs_mul.sv =====
// Shared signed multiplier with registered operands and registered product.
`default_nettype none

module hbs_mul (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 issue_i,
  input  wire logic signed [hbs_pkg::MUL_A_W-1:0]   op_a_i,
  input  wire logic signed [hbs_pkg::MUL_B_W-1:0]   op_b_i,
  output logic signed      [hbs_pkg::PROD_W-1:0]    prod_o
);
  import hbs_pkg::*;

  logic signed [MUL_A_W-1:0] op_a_q;
  logic signed [MUL_B_W-1:0] op_b_q;
  logic signed [PROD_W-1:0]  prod_q;

  // Operands load on issue and then hold, so the product stays put
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_a_q <= '0;
      op_b_q <= '0;
    end else if (issue_i) begin
      op_a_q <= op_a_i;
      op_b_q <= op_b_i;
    end
  end

  // Product register, fed from the operand registers
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a_q) * PROD_W'(op_b_q);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== sv/hbs_grid_mem.sv =====
// Single-port height store with a zero-fill sweep after reset.
`default_nettype none

module hbs_grid_mem #(
  parameter int DEPTH = hbs_pkg::MAX_COLUMNS_DEF * hbs_pkg::MAX_ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                addr_i,
  input  wire logic [hbs_pkg::HGT_W-1:0]    wdata_i,
  output logic      [hbs_pkg::HGT_W-1:0]    rdata_o,
  output logic                              clear_busy_o
);
  import hbs_pkg::*;

  logic [HGT_W-1:0] mem [DEPTH];
  logic [HGT_W-1:0] rdata_q;
  logic [AW-1:0]    clr_addr_q;
  logic             clr_busy_q;

  // Zero-fill sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Array port: sweep has the port while it runs
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o      = rdata_q;
  assign clear_busy_o = clr_busy_q;

endmodule

`default_nettype wire

// ===== sv/heightmap_bilinear_sampler.sv =====
// Height grid store with bilinear sampling at world positions (signed Q16.16).
// A write item goes straight into the grid memory; the next item may be accepted in the following cycle.
// A sample item runs through a state sequence set by one shared multiplier used five times
// and four reads of the single-port grid memory; no new item is accepted until it is done.
// After reset all MAX_COLUMNS*MAX_ROWS entries of the store (65536 by default) are swept to
// zero; no item is accepted during the sweep, configuration writes are.
`default_nettype none

module heightmap_bilinear_sampler #(
  parameter int MAX_COLUMNS = hbs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = hbs_pkg::MAX_ROWS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [hbs_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire logic [hbs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input items
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: column[7:0], row[15:8], height[47:16], world_x[79:48], world_z[111:80]
  input  wire logic [hbs_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: action[0]
  input  wire logic                              s_axis_tuser_i,
  // result items
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // tdata: sampled_height[31:0]
  output logic [hbs_pkg::HGT_W-1:0]              m_axis_tdata_o
);
  import hbs_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int LW    = (CW > RW) ? CW : RW;
  localparam int MAXSZ = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int SW    = $clog2(MAXSZ + 1);
  localparam int PH_W  = PROD_W - 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPX,
    ST_OPZ,
    ST_LOCX,
    ST_LOCZ,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_BL_TOP,
    ST_BL_BOT,
    ST_SUM_TOP,
    ST_SUM_BOT,
    ST_FIN_OP,
    ST_FIN_WAIT,
    ST_FIN_SUM
  } state_e;

  // Configuration registers
  logic [SIZE_REG_W-1:0]   cfg_cols_q;
  logic [SIZE_REG_W-1:0]   cfg_rows_q;
  logic signed [HGT_W-1:0] cfg_orig_x_q;
  logic signed [HGT_W-1:0] cfg_orig_z_q;
  logic [INV_W-1:0]        cfg_inv_q;

  // Sequencer and datapath registers
  state_e                  state_q;
  logic signed [HGT_W-1:0] wx_q;
  logic signed [HGT_W-1:0] wz_q;
  logic [CW-1:0]           cx_q;
  logic [RW-1:0]           cz_q;
  logic [WEIGHT_W-1:0]     tx_q;
  logic [WEIGHT_W-1:0]     tz_q;
  logic signed [HGT_W-1:0] h00_q;
  logic signed [HGT_W-1:0] h10_q;
  logic signed [HGT_W-1:0] h01_q;
  logic signed [HGT_W-1:0] h11_q;
  logic signed [HGT_W-1:0] top_q;
  logic signed [HGT_W-1:0] bot_q;
  logic                    out_valid_q;
  logic [HGT_W-1:0]        out_data_q;

  // Combinational signals
  logic [SW-1:0]               cols_eff;
  logic [SW-1:0]               rows_eff;
  logic [INV_W-1:0]            inv_eff;
  logic                        s_fire;
  logic                        slot_free;
  logic                        wr_inside;
  logic [7:0]                  in_column;
  logic [7:0]                  in_row;
  logic                        mem_en;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [HGT_W-1:0]            mem_rdata;
  logic                        clear_busy;
  logic [CW-1:0]               rd_col;
  logic [RW-1:0]               rd_row;
  logic                        mul_issue;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic [SW-1:0]               loc_size;
  logic [LW-1:0]               loc_cell;
  logic [WEIGHT_W-1:0]         loc_wt;
  logic signed [34:0]          sum_a;

  // Effective sizes clamped to 2..MAX, zero reciprocal acts as one
  always_comb begin
    if (cfg_cols_q < SIZE_REG_W'(2)) begin
      cols_eff = SW'(2);
    end else if (32'(cfg_cols_q) > MAX_COLUMNS) begin
      cols_eff = SW'(MAX_COLUMNS);
    end else begin
      cols_eff = SW'(cfg_cols_q);
    end
    if (cfg_rows_q < SIZE_REG_W'(2)) begin
      rows_eff = SW'(2);
    end else if (32'(cfg_rows_q) > MAX_ROWS) begin
      rows_eff = SW'(MAX_ROWS);
    end else begin
      rows_eff = SW'(cfg_rows_q);
    end
    inv_eff = (cfg_inv_q == '0) ? INV_ONE : cfg_inv_q;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q   <= SIZE_REG_W'(2);
      cfg_rows_q   <= SIZE_REG_W'(2);
      cfg_orig_x_q <= '0;
      cfg_orig_z_q <= '0;
      cfg_inv_q    <= INV_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_GRID_COLUMNS: cfg_cols_q   <= cfg_wdata_i[SIZE_REG_W-1:0];
        REG_GRID_ROWS:    cfg_rows_q   <= cfg_wdata_i[SIZE_REG_W-1:0];
        REG_ORIGIN_X:     cfg_orig_x_q <= cfg_wdata_i;
        REG_ORIGIN_Z:     cfg_orig_z_q <= cfg_wdata_i;
        REG_INV_CELL:     cfg_inv_q    <= cfg_wdata_i[INV_W-1:0];
        default:          ;
      endcase
    end
  end

  // Handshake
  assign s_axis_tready_o = (state_q == ST_IDLE) && !clear_busy;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign in_column       = s_axis_tdata_i[7:0];
  assign in_row          = s_axis_tdata_i[15:8];
  assign wr_inside       = (32'(in_column) < 32'(cols_eff)) && (32'(in_row) < 32'(rows_eff));

  // Memory port: height writes straight from the input, corner reads in sequence
  always_comb begin
    rd_col = cx_q;
    rd_row = cz_q;
    unique case (state_q)
      ST_RD1: rd_col = cx_q + CW'(1);
      ST_RD2: rd_row = cz_q + RW'(1);
      ST_RD3: begin
        rd_col = cx_q + CW'(1);
        rd_row = cz_q + RW'(1);
      end
      default: ;
    endcase
    mem_we = s_fire && (s_axis_tuser_i == ACT_WRITE) && wr_inside;
    mem_en = mem_we || (state_q == ST_RD0) || (state_q == ST_RD1) ||
             (state_q == ST_RD2) || (state_q == ST_RD3);
    if (mem_we) begin
      mem_addr = AW'(32'(in_row) * MAX_COLUMNS + 32'(in_column));
    end else begin
      mem_addr = AW'(32'(rd_row) * MAX_COLUMNS + 32'(rd_col));
    end
  end

  hbs_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (mem_en),
    .we_i         (mem_we),
    .addr_i       (mem_addr),
    .wdata_i      (s_axis_tdata_i[47:16]),
    .rdata_o      (mem_rdata),
    .clear_busy_o (clear_busy)
  );

  // Multiplier operand selection
  always_comb begin
    mul_issue = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_OPX: begin
        mul_a = MUL_A_W'(wx_q) - MUL_A_W'(cfg_orig_x_q);
        mul_b = MUL_B_W'(inv_eff);
      end
      ST_OPZ: begin
        mul_a = MUL_A_W'(wz_q) - MUL_A_W'(cfg_orig_z_q);
        mul_b = MUL_B_W'(inv_eff);
      end
      ST_BL_TOP: begin
        mul_a = MUL_A_W'(h10_q) - MUL_A_W'(h00_q);
        mul_b = MUL_B_W'(tx_q);
      end
      ST_BL_BOT: begin
        mul_a = MUL_A_W'(h11_q) - MUL_A_W'(h01_q);
        mul_b = MUL_B_W'(tx_q);
      end
      ST_FIN_OP: begin
        mul_a = MUL_A_W'(bot_q) - MUL_A_W'(top_q);
        mul_b = MUL_B_W'(tz_q);
      end
      default: mul_issue = 1'b0;
    endcase
  end

  hbs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (mul_issue),
    .op_a_i  (mul_a),
    .op_b_i  (mul_b),
    .prod_o  (prod)
  );

  // Cell and weight from a signed Q27.32 grid coordinate, clamped to the grid
  always_comb begin
    loc_size = (state_q == ST_LOCX) ? cols_eff : rows_eff;
    if (prod[PROD_W-1]) begin
      loc_cell = '0;
      loc_wt   = '0;
    end else if (prod[PROD_W-1:32] >= PH_W'(loc_size - SW'(1))) begin
      loc_cell = LW'(loc_size - SW'(2));
      loc_wt   = WEIGHT_ONE;
    end else begin
      loc_cell = prod[32 +: LW];
      loc_wt   = {1'b0, prod[31:16]};
    end
  end

  // Blend adder: base value picked by the state
  always_comb begin
    unique case (state_q)
      ST_SUM_TOP: sum_a = blend_sum(h00_q, prod);
      ST_SUM_BOT: sum_a = blend_sum(h01_q, prod);
      default:    sum_a = blend_sum(top_q, prod);
    endcase
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      wx_q        <= '0;
      wz_q        <= '0;
      cx_q        <= '0;
      cz_q        <= '0;
      tx_q        <= '0;
      tz_q        <= '0;
      h00_q       <= '0;
      h10_q       <= '0;
      h01_q       <= '0;
      h11_q       <= '0;
      top_q       <= '0;
      bot_q       <= '0;
    end else begin
      // result valid: set by the last step, dropped once taken
      if ((state_q == ST_FIN_SUM) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire && (s_axis_tuser_i == ACT_SAMPLE)) begin
            wx_q    <= s_axis_tdata_i[79:48];
            wz_q    <= s_axis_tdata_i[111:80];
            state_q <= ST_OPX;
          end
        end
        ST_OPX:  state_q <= ST_OPZ;
        ST_OPZ:  state_q <= ST_LOCX;
        ST_LOCX: begin
          cx_q    <= CW'(loc_cell);
          tx_q    <= loc_wt;
          state_q <= ST_LOCZ;
        end
        ST_LOCZ: begin
          cz_q    <= RW'(loc_cell);
          tz_q    <= loc_wt;
          state_q <= ST_RD0;
        end
        ST_RD0: state_q <= ST_RD1;
        ST_RD1: begin
          h00_q   <= mem_rdata;
          state_q <= ST_RD2;
        end
        ST_RD2: begin
          h10_q   <= mem_rdata;
          state_q <= ST_RD3;
        end
        ST_RD3: begin
          h01_q   <= mem_rdata;
          state_q <= ST_BL_TOP;
        end
        ST_BL_TOP: begin
          h11_q   <= mem_rdata;
          state_q <= ST_BL_BOT;
        end
        ST_BL_BOT: state_q <= ST_SUM_TOP;
        ST_SUM_TOP: begin
          top_q   <= sum_a[HGT_W-1:0];
          state_q <= ST_SUM_BOT;
        end
        ST_SUM_BOT: begin
          bot_q   <= sum_a[HGT_W-1:0];
          state_q <= ST_FIN_OP;
        end
        ST_FIN_OP:   state_q <= ST_FIN_WAIT;
        ST_FIN_WAIT: state_q <= ST_FIN_SUM;
        ST_FIN_SUM: begin
          // hold until the output register is free
          if (slot_free) begin
            out_data_q  <= saturate(sum_a);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

// ===== test/tb_heightmap_bilinear_sampler.sv =====
// Self-checking bench for the height grid sampler: directed and random writes and samples against a predictor.
module tb_heightmap_bilinear_sampler;
  import hbs_pkg::*;

  localparam int GRID_COLS   = MAX_COLUMNS_DEF;
  localparam int GRID_ROWS   = MAX_ROWS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int WRITE_SETTLE = 20;
  localparam int END_SETTLE   = 40;

  // indexes past the register list, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic             action;
    logic [7:0]       column;
    logic [7:0]       row;
    logic [HGT_W-1:0] height;
    logic [HGT_W-1:0] world_x;
    logic [HGT_W-1:0] world_z;
  } grid_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [IN_DATA_W-1:0] in_data  = '0;
  logic                 in_kind  = ACT_WRITE;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [HGT_W-1:0] out_data;

  heightmap_bilinear_sampler i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_kind),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: register copies and the height grid
  logic [SIZE_REG_W-1:0] cols_reg   = 9'd2;
  logic [SIZE_REG_W-1:0] rows_reg   = 9'd2;
  logic [HGT_W-1:0]      origin_x_reg = '0;
  logic [HGT_W-1:0]      origin_z_reg = '0;
  logic [INV_W-1:0]      inv_cell_reg = INV_ONE;
  logic [HGT_W-1:0]      height_mem [GRID_COLS*GRID_ROWS];

  grid_item_t       pending_items[$];
  logic [HGT_W-1:0] expected_heights[$];

  grid_item_t       cur_item;
  logic [HGT_W-1:0] want_height;
  int               error_count = 0;
  int               cycle_count = 0;
  int               tx_wait = 0;
  int               rx_wait = 0;
  bit               tx_quiet = 1'b0;
  bit               rx_quiet = 1'b0;
  bit               tx_free;

  function automatic int eff_size(input logic [SIZE_REG_W-1:0] v, input int max_v);
    if (v < 2) return 2;
    if (v > max_v) return max_v;
    return int'(v);
  endfunction

  // zero reciprocal stands for one
  function automatic longint eff_scale();
    return (inv_cell_reg == '0) ? 65536 : longint'(inv_cell_reg);
  endfunction

  // world coordinate to lower cell index and Q16.16 weight along one axis
  function automatic void locate_axis(input logic [HGT_W-1:0] world,
                                      input logic [HGT_W-1:0] origin, input int size,
                                      output int cell_idx, output longint weight);
    longint diff;
    longint prod;
    longint pos;
    longint top;
    diff = longint'($signed(world)) - longint'($signed(origin));
    prod = diff * eff_scale();
    pos  = (prod < 0) ? 0 : (prod >>> 16);
    top  = longint'(size - 1) <<< 16;
    if (pos > top) pos = top;
    cell_idx = int'(pos >>> 16);
    if (cell_idx > size - 2) cell_idx = size - 2;
    weight = pos - (longint'(cell_idx) <<< 16);
  endfunction

  function automatic longint lerp_q16(input longint a, input longint b, input longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic longint corner_height(input int c, input int r);
    return longint'($signed(height_mem[r * GRID_COLS + c]));
  endfunction

  // Apply one item: a write updates the grid, a sample queues its expected height
  function automatic void bilinear_predict(input grid_item_t it);
    int     cols;
    int     rows;
    int     cx;
    int     cz;
    longint tx;
    longint tz;
    longint top_edge;
    longint bottom_edge;
    longint mixed;
    cols = eff_size(cols_reg, GRID_COLS);
    rows = eff_size(rows_reg, GRID_ROWS);
    if (it.action == ACT_WRITE) begin
      if (int'(it.column) < cols && int'(it.row) < rows) begin
        height_mem[int'(it.row) * GRID_COLS + int'(it.column)] = it.height;
      end
    end else begin
      locate_axis(it.world_x, origin_x_reg, cols, cx, tx);
      locate_axis(it.world_z, origin_z_reg, rows, cz, tz);
      top_edge    = lerp_q16(corner_height(cx, cz), corner_height(cx + 1, cz), tx);
      bottom_edge = lerp_q16(corner_height(cx, cz + 1), corner_height(cx + 1, cz + 1), tx);
      mixed       = lerp_q16(top_edge, bottom_edge, tz);
      if (mixed > 64'sd2147483647) mixed = 64'sd2147483647;
      if (mixed < -64'sd2147483648) mixed = -64'sd2147483648;
      expected_heights.push_back(32'(mixed));
    end
  endfunction

  // Driver: presents queued items, random gap after each accepted one
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      tx_free = !in_valid;
      if (in_valid && in_ready) begin
        bilinear_predict(cur_item);
        tx_free = 1'b1;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        tx_wait = tx_quiet ? 0 : $urandom_range(0, 17);
      end
      if (tx_free) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_data  <= {cur_item.world_z, cur_item.world_x, cur_item.height,
                       cur_item.row, cur_item.column};
          in_kind  <= cur_item.action;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item, random stall after each one
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_heights.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("result %h with no sample outstanding", out_data);
        end else begin
          want_height = expected_heights.pop_front();
          if (out_data !== want_height) begin
            error_count++;
            if (error_count <= 10) begin
              $display("sampled_height mismatch: expected %h, got %h", want_height, out_data);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 17);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GRID_COLUMNS: cols_reg = val[SIZE_REG_W-1:0];
      REG_GRID_ROWS:    rows_reg = val[SIZE_REG_W-1:0];
      REG_ORIGIN_X:     origin_x_reg = val;
      REG_ORIGIN_Z:     origin_z_reg = val;
      REG_INV_CELL:     inv_cell_reg = val[INV_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk, which must be dropped
  task automatic set_grid(input logic [SIZE_REG_W-1:0] cols, input logic [SIZE_REG_W-1:0] rows,
                          input logic [HGT_W-1:0] ox, input logic [HGT_W-1:0] oz,
                          input logic [INV_W-1:0] inv);
    cfg_write(REG_GRID_COLUMNS, {23'($urandom), cols});
    cfg_write(REG_GRID_ROWS, {23'($urandom), rows});
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Z, oz);
    cfg_write(REG_INV_CELL, {7'($urandom), inv});
  endtask

  // nothing queued, nothing presented, nothing outstanding; then let a last write land
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_heights.size() != 0);
    repeat (WRITE_SETTLE) @(posedge clk);
  endtask

  task automatic push_write(input logic [7:0] col, input logic [7:0] row,
                            input logic [HGT_W-1:0] h);
    grid_item_t it;
    it = '{ACT_WRITE, col, row, h, $urandom, $urandom};
    pending_items.push_back(it);
  endtask

  task automatic push_sample(input logic [HGT_W-1:0] wx, input logic [HGT_W-1:0] wz);
    grid_item_t it;
    it = '{ACT_SAMPLE, 8'($urandom), 8'($urandom), $urandom, wx, wz};
    pending_items.push_back(it);
  endtask

  // world coordinate that maps back onto a given grid position
  function automatic logic [HGT_W-1:0] world_from_grid(input longint pos,
                                                       input logic [HGT_W-1:0] origin);
    return 32'(longint'($signed(origin)) + (pos * 64'sd65536) / eff_scale());
  endfunction

  // mostly near the focus cell, so writes and samples meet
  function automatic logic [7:0] pick_index(input int size, input int focus);
    int idx;
    if ($urandom_range(0, 9) < 7) begin
      idx = focus + $urandom_range(0, 3);
      if (idx > size - 1) idx = size - 1;
    end else begin
      idx = $urandom_range(0, size - 1);
    end
    return 8'(idx);
  endfunction

  function automatic longint pick_pos(input int size, input int focus);
    int     sel;
    longint base;
    longint pos;
    longint top;
    sel = $urandom_range(0, 15);
    top = longint'(size - 1) <<< 16;
    if (sel == 0) return 0;
    if (sel == 1) return top;
    base = (sel < 10) ? longint'(focus + $urandom_range(0, 2)) : longint'($urandom_range(0, size - 2));
    pos  = (base <<< 16) + ((sel == 2) ? 0 : longint'($urandom_range(0, 65535)));
    return (pos > top) ? top : pos;
  endfunction

  function automatic logic [HGT_W-1:0] random_height();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1:       return 32'($signed(20'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int n_items);
    int cols;
    int rows;
    int focus_c;
    int focus_r;
    int kind;
    cols    = eff_size(cols_reg, GRID_COLS);
    rows    = eff_size(rows_reg, GRID_ROWS);
    focus_c = $urandom_range(0, cols - 2);
    focus_r = $urandom_range(0, rows - 2);
    for (int i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        push_write(pick_index(cols, focus_c), pick_index(rows, focus_r), random_height());
      end else if (kind == 4) begin
        push_write(8'($urandom), 8'($urandom), $urandom);
      end else if (kind < 9) begin
        push_sample(world_from_grid(pick_pos(cols, focus_c), origin_x_reg),
                    world_from_grid(pick_pos(rows, focus_r), origin_z_reg));
      end else begin
        push_sample($urandom, $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < GRID_COLS * GRID_ROWS; i++) height_mem[i] = '0;

    // Directed items on the reset 2x2 grid: extreme corners, outside writes, clamped samples
    push_write(8'd0, 8'd0, 32'h7FFF_FFFF);
    push_write(8'd1, 8'd0, 32'h8000_0000);
    push_write(8'd0, 8'd1, 32'h0001_0000);
    push_write(8'd1, 8'd1, 32'hFFFF_0000);
    push_write(8'd2, 8'd0, $urandom);
    push_write(8'd0, 8'd2, $urandom);
    push_write(8'hFF, 8'hFF, $urandom);
    push_sample(32'h0000_0000, 32'h0000_0000);
    push_sample(32'h0001_0000, 32'h0000_0000);
    push_sample(32'h0000_8000, 32'h0000_8000);
    push_sample(32'h8000_0000, 32'h8000_0000);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_sample(32'h0000_4000, 32'h0000_C000);
    push_sample(32'h0001_0000, 32'h0001_0000);
    push_sample($urandom, $urandom);
    push_write(8'd1, 8'd1, 32'h0000_0000);
    push_sample(32'h0000_FFFF, 32'h0001_0000);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait_idle();
    set_grid(9'd256, 9'd256, 32'h0, 32'h0, INV_ONE);
    random_phase(170);

    // tiny grid, zero reciprocal, junk in the unused register slots
    wait_idle();
    set_grid(9'd2, 9'd2, $urandom, $urandom, 25'd0);
    cfg_write(REG_SPARE_LO, $urandom);
    cfg_write(REG_SPARE_HI, $urandom);
    random_phase(120);

    // sizes beyond both ends, largest reciprocal
    wait_idle();
    set_grid(9'd0, 9'd511, 32'h8000_0000, 32'h7FFF_0000, 25'h1FF_FFFF);
    random_phase(150);

    // oversize columns, one row, smallest reciprocal
    wait_idle();
    set_grid(9'd300, 9'd1, 32'h7FFF_FFFF, 32'h8000_0000, 25'd1);
    random_phase(150);

    wait_idle();
    set_grid(9'($urandom_range(2, 256)), 9'($urandom_range(2, 256)), $urandom, $urandom,
             25'($urandom_range(4096, 1 << 20)));
    random_phase(200);

    wait_idle();
    set_grid(9'($urandom_range(2, 40)), 9'($urandom_range(2, 40)),
             32'($signed(24'($urandom))), 32'($signed(24'($urandom))), 25'($urandom));
    random_phase(200);

    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hbs_pkg.sv
sv/hbs_mul.sv
sv/hbs_grid_mem.sv
sv/heightmap_bilinear_sampler.sv
test/tb_heightmap_bilinear_sampler.sv
